>>> design/rsd_pkg.sv
`default_nettype none

package rsd_pkg;

  // Capacity of the record store and the counter widths that follow from it.
  localparam int MAX_RECORDS = 32;
  localparam int ADDR_W      = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  // Field widths of one record.
  localparam int KEY_W  = 12;
  localparam int AVG_W  = 10;
  localparam int OBP_W  = 10;
  localparam int YEAR_W = 12;
  localparam int TAG_W  = 8;

  // One stored record, 52 bits.
  typedef struct packed {
    logic [KEY_W-1:0]  slugging;
    logic [AVG_W-1:0]  batting_avg;
    logic [OBP_W-1:0]  on_base_pct;
    logic [YEAR_W-1:0] season_year;
    logic [TAG_W-1:0]  record_tag;
  } rec_t;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CARRY,
    OP_STEP,
    OP_FLUSH
  } op_t;

  // Command bundle from controller to datapath.
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              out_load;
    logic              out_last;
    logic              out_ovf;
  } cmd_t;

  // Status bundle from datapath to controller.
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> design/rsd_if.sv
`default_nettype none

// Record input channel.
interface rsd_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] in_slugging;
  logic [9:0]  in_batting_avg;
  logic [9:0]  in_on_base_pct;
  logic [11:0] in_season_year;
  logic [7:0]  in_record_tag;
  logic        in_is_last;

  modport source (
    output valid, in_slugging, in_batting_avg, in_on_base_pct,
           in_season_year, in_record_tag, in_is_last,
    input  ready
  );
  modport sink (
    input  valid, in_slugging, in_batting_avg, in_on_base_pct,
           in_season_year, in_record_tag, in_is_last,
    output ready
  );
endinterface

// Sorted result channel.
interface rsd_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_slugging;
  logic [9:0]  out_batting_avg;
  logic [9:0]  out_on_base_pct;
  logic [11:0] out_season_year;
  logic [7:0]  out_record_tag;
  logic        out_is_last;
  logic        out_overflow;

  modport source (
    output valid, out_slugging, out_batting_avg, out_on_base_pct,
           out_season_year, out_record_tag, out_is_last, out_overflow,
    input  ready
  );
  modport sink (
    input  valid, out_slugging, out_batting_avg, out_on_base_pct,
           out_season_year, out_record_tag, out_is_last, out_overflow,
    output ready
  );
endinterface

`default_nettype wire

>>> design/record_sort_descending_by_key_top.sv
`default_nettype none

// Channel   Dir  Handshake        Payload
// in_ch     in   valid / ready    one record and its last mark
// out_ch    out  valid / ready    one sorted record, last and overflow flags
//
// A record is taken whenever in_ch.valid is high while the block collects
// a set. After the last record, n stored records are sorted in n-1 passes
// over the record store, then emitted one at a time, each read from the
// store and then loaded into the output register.
// Reset clears the state, the record count, the overflow flag and the
// output valid; store contents are not cleared. in_ch.ready is low from
// the last record until the final result is loaded; out_ch stalls hold
// emission in place.
module record_sort_descending_by_key_top (
  input  wire logic clk,
  input  wire logic rst_n,
  rsd_in_if.sink    in_ch,
  rsd_out_if.source out_ch
);
  import rsd_pkg::*;

  rec_t  in_rec;
  rec_t  out_rec;
  cmd_t  cmd;
  stat_t stat;

  assign in_rec.slugging    = in_ch.in_slugging;
  assign in_rec.batting_avg = in_ch.in_batting_avg;
  assign in_rec.on_base_pct = in_ch.in_on_base_pct;
  assign in_rec.season_year = in_ch.in_season_year;
  assign in_rec.record_tag  = in_ch.in_record_tag;

  rsd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_is_last (in_ch.in_is_last),
    .in_ready   (in_ch.ready),
    .cmd        (cmd),
    .stat       (stat)
  );

  rsd_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_rec    (in_rec),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_rec   (out_rec),
    .out_last  (out_ch.out_is_last),
    .out_ovf   (out_ch.out_overflow)
  );

  assign out_ch.out_slugging    = out_rec.slugging;
  assign out_ch.out_batting_avg = out_rec.batting_avg;
  assign out_ch.out_on_base_pct = out_rec.on_base_pct;
  assign out_ch.out_season_year = out_rec.season_year;
  assign out_ch.out_record_tag  = out_rec.record_tag;

endmodule

`default_nettype wire

>>> design/rsd_dpath.sv
`default_nettype none

module rsd_dpath (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire rsd_pkg::rec_t  in_rec,
  input  wire rsd_pkg::cmd_t  cmd,
  output rsd_pkg::stat_t    stat,
  input  wire logic         out_ready,
  output logic              out_valid,
  output rsd_pkg::rec_t     out_rec,
  output logic              out_last,
  output logic              out_ovf
);
  import rsd_pkg::*;

  rec_t mem [MAX_RECORDS];
  rec_t rdata_r;
  rec_t carry_r;
  rec_t wr_data;
  logic wr_en;
  logic swap;

  rec_t out_rec_r;
  logic out_last_r;
  logic out_ovf_r;
  logic out_valid_r;
  logic out_valid_nxt;

  // The carried record moves on when the next key is strictly larger.
  assign swap = carry_r.slugging < rdata_r.slugging;

  // Write port data: a new record, the larger of a compared pair, or the carry.
  always_comb begin
    wr_en   = 1'b0;
    wr_data = in_rec;
    case (cmd.op)
      OP_LOAD: begin
        wr_en   = 1'b1;
        wr_data = in_rec;
      end
      OP_STEP: begin
        wr_en   = 1'b1;
        wr_data = swap ? rdata_r : carry_r;
      end
      OP_FLUSH: begin
        wr_en   = 1'b1;
        wr_data = carry_r;
      end
      default: begin
        wr_en   = 1'b0;
        wr_data = in_rec;
      end
    endcase
  end

  // Record store with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cmd.wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[cmd.rd_addr];
    end
  end

  // Carry register holds the record that bubbles along the current pass.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CARRY || (cmd.op == OP_STEP && !swap)) begin
      carry_r <= rdata_r;
    end
  end

  // Output register decouples emission from the downstream stall.
  assign stat.out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_rec_r  <= rdata_r;
      out_last_r <= cmd.out_last;
      out_ovf_r  <= cmd.out_ovf;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rec   = out_rec_r;
  assign out_last  = out_last_r;
  assign out_ovf   = out_ovf_r;

endmodule

`default_nettype wire

>>> design/rsd_ctrl.sv
`default_nettype none

module rsd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_is_last,
  output logic               in_ready,
  output rsd_pkg::cmd_t      cmd,
  input  wire rsd_pkg::stat_t stat
);
  import rsd_pkg::*;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_FIRST,
    ST_CARRY,
    ST_STEP,
    ST_FLUSH,
    ST_EREAD,
    ST_EPUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  logic [ADDR_W-1:0] pass_r, pass_nxt;

  logic [CNT_W-1:0]  k_ext;
  logic [CNT_W-1:0]  k_plus1;
  logic [CNT_W-1:0]  k_plus2;
  logic [CNT_W-1:0]  pass_plus1;
  logic              accept;

  assign k_ext      = CNT_W'(k_r);
  assign k_plus1    = k_ext + CNT_W'(1);
  assign k_plus2    = k_ext + CNT_W'(2);
  assign pass_plus1 = CNT_W'(pass_r) + CNT_W'(1);

  assign in_ready = (state_r == ST_COLLECT);
  assign accept   = in_valid && in_ready;

  // Sequencer: collect, then n-1 bubble passes, then emit in store order.
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    k_nxt        = k_r;
    pass_nxt     = pass_r;
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.out_ovf  = ovf_r;
    cmd.out_last = (k_plus1 == count_r);
    case (state_r)
      ST_COLLECT: begin
        cmd.wr_addr = count_r[ADDR_W-1:0];
        if (accept) begin
          if (count_r < CNT_W'(MAX_RECORDS)) begin
            cmd.op    = OP_LOAD;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_is_last) begin
            k_nxt    = '0;
            pass_nxt = ADDR_W'(1);
            // A single stored record needs no sorting.
            if (count_nxt < CNT_W'(2)) begin
              state_nxt = ST_EREAD;
            end else begin
              state_nxt = ST_FIRST;
            end
          end
        end
      end
      ST_FIRST: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = '0;
        state_nxt   = ST_CARRY;
      end
      ST_CARRY: begin
        cmd.op      = OP_CARRY;
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = ADDR_W'(1);
        k_nxt       = '0;
        state_nxt   = ST_STEP;
      end
      ST_STEP: begin
        // Compare the carry with entry k+1 and settle entry k.
        cmd.op      = OP_STEP;
        cmd.wr_addr = k_r;
        if (k_plus2 < count_r) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = k_plus2[ADDR_W-1:0];
          k_nxt       = k_plus1[ADDR_W-1:0];
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // The carry ends the pass in the last entry.
        cmd.op      = OP_FLUSH;
        cmd.wr_addr = k_plus1[ADDR_W-1:0];
        k_nxt       = '0;
        if (pass_plus1 < count_r) begin
          pass_nxt  = pass_plus1[ADDR_W-1:0];
          state_nxt = ST_FIRST;
        end else begin
          state_nxt = ST_EREAD;
        end
      end
      ST_EREAD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = k_r;
        state_nxt   = ST_EPUT;
      end
      ST_EPUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (k_plus1 == count_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_COLLECT;
          end else begin
            k_nxt     = k_plus1[ADDR_W-1:0];
            state_nxt = ST_EREAD;
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      count_r <= '0;
      ovf_r   <= 1'b0;
      k_r     <= '0;
      pass_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      k_r     <= k_nxt;
      pass_r  <= pass_nxt;
    end
  end

endmodule

`default_nettype wire
